>>> rtl/core/plps_pkg.sv
// ----------------------------------------------------------------------------
// plps_pkg
// Shared widths, reset values and register indexes of the point light
// shading pipeline.
// ----------------------------------------------------------------------------
package plps_pkg;

  localparam int FIX_W      = 32;
  localparam int SHINE_W    = 16;
  localparam int RGB_W      = 24;
  localparam int STRENGTH_W = 16;
  localparam int DIM_W      = 16;
  localparam int CHAN_W     = 8;

  localparam int IN_DATA_W  = 9 * FIX_W + SHINE_W;
  localparam int OUT_DATA_W = 3 * FIX_W;
  localparam int HIT_LSB    = 0;
  localparam int NORM_LSB   = 3 * FIX_W;
  localparam int VIEW_LSB   = 6 * FIX_W;
  localparam int SHINE_LSB  = 9 * FIX_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_POS_X = 3'd0,
    REG_LIGHT_POS_Y = 3'd1,
    REG_LIGHT_POS_Z = 3'd2,
    REG_LIGHT_RGB   = 3'd3,
    REG_STRENGTH    = 3'd4,
    REG_REACH       = 3'd5,
    REG_DIM_RATE    = 3'd6
  } cfg_reg_t;

  localparam logic [RGB_W-1:0]      RGB_RST      = 24'hFFFFFF;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 16'd256;
  localparam logic [FIX_W-1:0]      REACH_RST    = 32'd65536;
  localparam logic [DIM_W-1:0]      DIM_RST      = 16'd256;

  typedef logic signed [FIX_W-1:0] fix_t;

  // square root unit
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  // normalising quotient: |v| << 30 / len, result at most 2^30
  localparam int FRAC_W  = 30;
  localparam int UNIT_W  = 31;
  localparam int UNUM_W  = FIX_W + FRAC_W;

  // brightness quotient
  localparam int BNUM_W   = 112;
  localparam int BDEN_W   = 80;
  localparam int BRIGHT_W = 32;

  localparam int ONE30 = 1073741824;

  localparam int SPEC_EXP_DEF = 32;

endpackage

>>> rtl/core/plps_isqrt.sv
// ----------------------------------------------------------------------------
// plps_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module plps_isqrt (
  input  logic                        clk,
  input  logic                        en_i,
  input  logic [plps_pkg::RAD_W-1:0]  rad_i,
  output logic [plps_pkg::ROOT_W-1:0] root_o
);

  localparam int RW = plps_pkg::RAD_W;
  localparam int N  = plps_pkg::ROOT_W;

  logic [RW-1:0] x_r   [N];
  logic [RW-1:0] r_r   [N];
  logic [RW-1:0] x_nxt [N];
  logic [RW-1:0] r_nxt [N];
  logic [RW-1:0] xs    [N+1];
  logic [RW-1:0] rs    [N+1];

  always_comb begin
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    xs[0] = rad_i;
    rs[0] = '0;
    for (int k = 0; k < N; k++) begin
      xs[k+1] = x_r[k];
      rs[k+1] = r_r[k];
    end
    for (int k = 0; k < N; k++) begin
      bitv  = RW'(1) << (RW - 2 - 2 * k);
      trial = rs[k] + bitv;
      if (xs[k] >= trial) begin
        x_nxt[k] = xs[k] - trial;
        r_nxt[k] = (rs[k] >> 1) + bitv;
      end else begin
        x_nxt[k] = xs[k];
        r_nxt[k] = rs[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      x_r <= x_nxt;
      r_r <= r_nxt;
    end
  end

  assign root_o = r_r[N-1][N-1:0];

endmodule

>>> rtl/core/plps_div.sv
// ----------------------------------------------------------------------------
// plps_div
// Pipelined restoring divider with an overflow check stage in front.
// ----------------------------------------------------------------------------
module plps_div #(
  parameter int NUM_W = plps_pkg::BNUM_W,
  parameter int DEN_W = plps_pkg::BDEN_W,
  parameter int QUO_W = plps_pkg::BRIGHT_W
) (
  input  logic             clk,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r   [QUO_W+1];
  logic [DEN_W-1:0] den_r   [QUO_W+1];
  logic [QUO_W-1:0] q_r     [QUO_W+1];
  logic             ovf_r   [QUO_W+1];
  logic [NUM_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] q_nxt   [QUO_W];
  logic             ovf_nxt;

  assign ovf_nxt = (den_i == '0) || (CW'(num_i) >= (CW'(den_i) << QUO_W));

  always_comb begin
    logic [CW-1:0] t;
    for (int j = 0; j < QUO_W; j++) begin
      t = CW'(den_r[j]) << (QUO_W - 1 - j);
      if (CW'(rem_r[j]) >= t) begin
        rem_nxt[j] = rem_r[j] - t[NUM_W-1:0];
        q_nxt[j]   = q_r[j] | (QUO_W'(1) << (QUO_W - 1 - j));
      end else begin
        rem_nxt[j] = rem_r[j];
        q_nxt[j]   = q_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_nxt;
      for (int j = 0; j < QUO_W; j++) begin
        rem_r[j+1] <= rem_nxt[j];
        den_r[j+1] <= den_r[j];
        q_r[j+1]   <= q_nxt[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end
  end

  assign quo_o = q_r[QUO_W];
  assign ovf_o = ovf_r[QUO_W];

endmodule

>>> rtl/core/point_light_phong_shading.sv
// ----------------------------------------------------------------------------
// point_light_phong_shading
// Diffuse and Phong specular light of one point light on one surface hit.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat enters per cycle while the output is not held.
// The depth is set by the 32-stage square root, the 32-stage normalising
// quotient and one multiply stage per step of the specular power; the
// brightness quotient runs alongside them. A held output freezes every
// stage and in_tready falls with it. Registers may only be written while
// no beat is in flight.
module point_light_phong_shading #(
  parameter int SPEC_EXPONENT = plps_pkg::SPEC_EXP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // hit_pos_x/y/z, surf_norm_x/y/z, view_dir_x/y/z, shine_factor
  input  logic [plps_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_shadow
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // add_red, add_green, add_blue
  output logic [plps_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FW       = plps_pkg::FIX_W;
  localparam int S_LEN    = 3 + plps_pkg::ROOT_W;
  localparam int S_UNIT   = S_LEN + 1 + plps_pkg::UNIT_W;
  localparam int S_ANG    = S_UNIT + 6;
  localparam int S_POW    = S_ANG + SPEC_EXPONENT;
  localparam int S_SPEC   = S_POW + 2;
  localparam int S_OUT    = S_SPEC + 1;
  localparam int S_BRIGHT = 6 + 1 + plps_pkg::BRIGHT_W;
  localparam int S_DIFF   = S_BRIGHT + 1;
  localparam int D_MAG    = S_LEN - 1;
  localparam int D_SGN    = S_UNIT - 1;
  localparam int D_SHINE  = S_POW;
  localparam int D_SHD    = S_SPEC - 1;
  localparam int D_DIFF   = S_SPEC - S_DIFF;
  localparam int UW       = plps_pkg::UNIT_W;

  // configuration
  plps_pkg::fix_t                    lpos_r [3];
  logic [plps_pkg::RGB_W-1:0]        rgb_r;
  logic [plps_pkg::STRENGTH_W-1:0]   strength_r;
  logic [FW-1:0]                     reach_r;
  logic [plps_pkg::DIM_W-1:0]        dim_r;

  logic                              adv;
  logic [S_OUT:1]                    vld_r;

  assign adv       = !vld_r[S_OUT] || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lpos_r[i] <= '0;
      end
      rgb_r      <= plps_pkg::RGB_RST;
      strength_r <= plps_pkg::STRENGTH_RST;
      reach_r    <= plps_pkg::REACH_RST;
      dim_r      <= plps_pkg::DIM_RST;
      vld_r      <= '0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[S_OUT-1:1], in_tvalid};
      end
      if (cfg_valid) begin
        unique case (plps_pkg::cfg_reg_t'(cfg_index))
          plps_pkg::REG_LIGHT_POS_X: lpos_r[0]  <= cfg_data;
          plps_pkg::REG_LIGHT_POS_Y: lpos_r[1]  <= cfg_data;
          plps_pkg::REG_LIGHT_POS_Z: lpos_r[2]  <= cfg_data;
          plps_pkg::REG_LIGHT_RGB:   rgb_r      <= cfg_data[plps_pkg::RGB_W-1:0];
          plps_pkg::REG_STRENGTH:    strength_r <= cfg_data[plps_pkg::STRENGTH_W-1:0];
          plps_pkg::REG_REACH:       reach_r    <= cfg_data;
          plps_pkg::REG_DIM_RATE:    dim_r      <= cfg_data[plps_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // entry: light vector, negated view, magnitudes and signs
  plps_pkg::fix_t        lsat   [3];
  plps_pkg::fix_t        nin    [3];
  logic [FW-1:0]         mag_in [9];
  logic [8:0]            sgn_in;

  always_comb begin
    logic signed [FW:0] ldiff;
    logic signed [FW:0] vneg;
    for (int i = 0; i < 3; i++) begin
      ldiff = {lpos_r[i][FW-1], lpos_r[i]}
            - {in_tdata[plps_pkg::HIT_LSB + FW*i + FW-1],
               in_tdata[plps_pkg::HIT_LSB + FW*i +: FW]};
      if (ldiff[FW] != ldiff[FW-1]) begin
        lsat[i] = ldiff[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
      end else begin
        lsat[i] = ldiff[FW-1:0];
      end
      nin[i] = in_tdata[plps_pkg::NORM_LSB + FW*i +: FW];
      vneg   = -$signed({in_tdata[plps_pkg::VIEW_LSB + FW*i + FW-1],
                         in_tdata[plps_pkg::VIEW_LSB + FW*i +: FW]});
      mag_in[i]   = lsat[i][FW-1] ? FW'(-lsat[i]) : FW'(lsat[i]);
      mag_in[3+i] = nin[i][FW-1] ? FW'(-nin[i]) : FW'(nin[i]);
      mag_in[6+i] = vneg[FW] ? FW'(-vneg) : vneg[FW-1:0];
      sgn_in[i]   = lsat[i][FW-1];
      sgn_in[3+i] = nin[i][FW-1];
      sgn_in[6+i] = vneg[FW];
    end
  end

  plps_pkg::fix_t                  l_s1_r   [3];
  plps_pkg::fix_t                  n_s1_r   [3];
  logic [FW-1:0]                   mag_s1_r [9];
  logic [8:0]                      sgn_s1_r;
  logic [plps_pkg::SHINE_W-1:0]    shine_s1_r;
  logic                            shd_s1_r;

  logic signed [2*FW-1:0]          nlp_r [3];
  logic [2*FW-1:0]                 sq_r  [9];
  logic [47:0]                     dd_r;
  logic [2*FW-1:0]                 sqs_r [3];
  logic [63:0]                     ds_r;
  logic [plps_pkg::BDEN_W-1:0]     den4_r;
  logic [63:0]                     ml_r;
  logic [63:0]                     mh_r;
  logic [plps_pkg::BDEN_W-1:0]     den5_r;
  logic [95:0]                     num_r;
  logic [plps_pkg::BDEN_W-1:0]     den6_r;

  logic [FW-1:0]                   mag_dly_r [D_MAG][9];
  logic [8:0]                      sgn_dly_r [D_SGN];
  logic [plps_pkg::SHINE_W-1:0]    shine_dly_r [D_SHINE];
  logic                            shd_dly_r [D_SHD];
  logic [FW-1:0]                   dif_r [3];
  logic [FW-1:0]                   dif_dly_r [D_DIFF][3];

  logic signed [49:0]              ddsum;
  logic [plps_pkg::BRIGHT_W-1:0]   bright;
  logic                            bovf;
  logic [plps_pkg::ROOT_W-1:0]     len [3];
  logic [UW-1:0]                   uq [9];
  logic                            uovf [9];

  plps_pkg::fix_t                  su   [9];
  plps_pkg::fix_t                  un_r [4][9];
  logic signed [2*FW-1:0]          pr_r [3];
  plps_pkg::fix_t                  nl_r;
  logic signed [2*FW-1:0]          q2_r [3];
  logic signed [FW:0]              rv_r [3];
  logic signed [2*FW:0]            rp_r [3];
  logic [UW-1:0]                   ang_r;
  logic [UW-1:0]                   pw_r  [SPEC_EXPONENT];
  logic [UW-1:0]                   pa_r  [SPEC_EXPONENT];
  logic [UW-1:0]                   pw_nxt[SPEC_EXPONENT];
  logic [46:0]                     sp_r;
  logic [FW-1:0]                   spec_r;
  logic [plps_pkg::OUT_DATA_W-1:0] out_r;

  logic signed [33:0]              nlsum;
  plps_pkg::fix_t                  nl_nxt;
  logic signed [35:0]              asum;
  logic [UW-1:0]                   ang_nxt;
  logic [FW-1:0]                   dif_nxt [3];
  logic [62:0]                     spp;
  logic [plps_pkg::OUT_DATA_W-1:0] out_nxt;

  assign ddsum = 50'(nlp_r[0] >>> 16) + 50'(nlp_r[1] >>> 16) + 50'(nlp_r[2] >>> 16);

  plps_div #(
    .NUM_W (plps_pkg::BNUM_W),
    .DEN_W (plps_pkg::BDEN_W),
    .QUO_W (plps_pkg::BRIGHT_W)
  ) u_bdiv (
    .clk   (clk),
    .en_i  (adv),
    .num_i ({num_r, 16'd0}),
    .den_i (den6_r),
    .quo_o (bright),
    .ovf_o (bovf)
  );

  for (genvar g = 0; g < 3; g++) begin : g_len
    plps_isqrt u_sqrt (
      .clk    (clk),
      .en_i   (adv),
      .rad_i  (sqs_r[g]),
      .root_o (len[g])
    );
  end

  for (genvar g = 0; g < 9; g++) begin : g_unit
    plps_div #(
      .NUM_W (plps_pkg::UNUM_W),
      .DEN_W (plps_pkg::ROOT_W),
      .QUO_W (UW)
    ) u_udiv (
      .clk   (clk),
      .en_i  (adv),
      .num_i ({mag_dly_r[D_MAG-1][g], plps_pkg::FRAC_W'(0)}),
      .den_i (len[g/3]),
      .quo_o (uq[g]),
      .ovf_o (uovf[g])
    );
  end

  always_comb begin
    logic [CHAN_BITS-1:0] c;
    logic [FW+7:0]        cp;
    logic [61:0]          pprod;
    logic [FW:0]          t;
    for (int j = 0; j < 9; j++) begin
      if (uovf[j]) begin
        su[j] = '0;
      end else if (sgn_dly_r[D_SGN-1][j]) begin
        su[j] = -$signed({1'b0, uq[j]});
      end else begin
        su[j] = $signed({1'b0, uq[j]});
      end
    end
    nlsum = 34'(pr_r[0] >>> 30) + 34'(pr_r[1] >>> 30) + 34'(pr_r[2] >>> 30);
    if (nlsum > 34'(plps_pkg::ONE30)) begin
      nl_nxt = FW'(plps_pkg::ONE30);
    end else if (nlsum < -34'(plps_pkg::ONE30)) begin
      nl_nxt = -FW'(plps_pkg::ONE30);
    end else begin
      nl_nxt = nlsum[FW-1:0];
    end
    asum = 36'(rp_r[0] >>> 30) + 36'(rp_r[1] >>> 30) + 36'(rp_r[2] >>> 30);
    if (asum < 0) begin
      ang_nxt = '0;
    end else if (asum > 36'(plps_pkg::ONE30)) begin
      ang_nxt = UW'(plps_pkg::ONE30);
    end else begin
      ang_nxt = asum[UW-1:0];
    end
    pw_nxt[0] = ang_r;
    for (int k = 1; k < SPEC_EXPONENT; k++) begin
      pprod     = pw_r[k-1] * pa_r[k-1];
      pw_nxt[k] = pprod[60:30];
    end
    for (int i = 0; i < 3; i++) begin
      c  = rgb_r[16 - 8*i +: CHAN_BITS];
      cp = c * bright;
      if (bovf) begin
        dif_nxt[i] = (c != '0) ? '1 : '0;
      end else begin
        dif_nxt[i] = (cp[FW+7:FW] != '0) ? '1 : cp[FW-1:0];
      end
    end
    spp = sp_r * shine_dly_r[D_SHINE-1];
    for (int i = 0; i < 3; i++) begin
      t = {1'b0, dif_dly_r[D_DIFF-1][i]} + {1'b0, spec_r};
      if (shd_dly_r[D_SHD-1]) begin
        out_nxt[FW*i +: FW] = '0;
      end else begin
        out_nxt[FW*i +: FW] = t[FW] ? '1 : t[FW-1:0];
      end
    end
  end

  localparam int CHAN_BITS = plps_pkg::CHAN_W;

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      for (int i = 0; i < 3; i++) begin
        l_s1_r[i] <= lsat[i];
        n_s1_r[i] <= nin[i];
      end
      mag_s1_r   <= mag_in;
      sgn_s1_r   <= sgn_in;
      shine_s1_r <= in_tdata[plps_pkg::SHINE_LSB +: plps_pkg::SHINE_W];
      shd_s1_r   <= in_tuser;
      // stage 2
      for (int i = 0; i < 3; i++) begin
        nlp_r[i] <= l_s1_r[i] * n_s1_r[i];
      end
      for (int j = 0; j < 9; j++) begin
        sq_r[j] <= mag_s1_r[j] * mag_s1_r[j];
      end
      // stage 3
      dd_r <= (ddsum < 0) ? '0 : ddsum[47:0];
      for (int i = 0; i < 3; i++) begin
        sqs_r[i] <= sq_r[3*i] + sq_r[3*i+1] + sq_r[3*i+2];
      end
      // stages 4 to 6, brightness operands
      ds_r   <= dd_r * strength_r;
      den4_r <= sqs_r[0] * dim_r;
      ml_r   <= ds_r[31:0] * reach_r;
      mh_r   <= ds_r[63:32] * reach_r;
      den5_r <= den4_r;
      num_r  <= {mh_r, 32'd0} + {32'd0, ml_r};
      den6_r <= den5_r;
      dif_r  <= dif_nxt;
      // alignment lines
      mag_dly_r[0]   <= mag_s1_r;
      sgn_dly_r[0]   <= sgn_s1_r;
      shine_dly_r[0] <= shine_s1_r;
      shd_dly_r[0]   <= shd_s1_r;
      dif_dly_r[0]   <= dif_r;
      for (int k = 1; k < D_MAG; k++) begin
        mag_dly_r[k] <= mag_dly_r[k-1];
      end
      for (int k = 1; k < D_SGN; k++) begin
        sgn_dly_r[k] <= sgn_dly_r[k-1];
      end
      for (int k = 1; k < D_SHINE; k++) begin
        shine_dly_r[k] <= shine_dly_r[k-1];
      end
      for (int k = 1; k < D_SHD; k++) begin
        shd_dly_r[k] <= shd_dly_r[k-1];
      end
      for (int k = 1; k < D_DIFF; k++) begin
        dif_dly_r[k] <= dif_dly_r[k-1];
      end
      // reflection
      un_r[0] <= su;
      for (int k = 1; k < 4; k++) begin
        un_r[k] <= un_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        pr_r[i] <= su[3+i] * su[i];
        q2_r[i] <= nl_r * un_r[1][3+i];
        rv_r[i] <= (FW+1)'(q2_r[i] >>> 29) - (FW+1)'(un_r[2][i]);
        rp_r[i] <= rv_r[i] * un_r[3][6+i];
      end
      nl_r  <= nl_nxt;
      ang_r <= ang_nxt;
      // power
      pw_r    <= pw_nxt;
      pa_r[0] <= ang_r;
      for (int k = 1; k < SPEC_EXPONENT; k++) begin
        pa_r[k] <= pa_r[k-1];
      end
      sp_r   <= strength_r * pw_r[SPEC_EXPONENT-1];
      spec_r <= spp[61:30];
      out_r  <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[S_OUT];
  assign out_tdata  = out_r;

  a_shadow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_SPEC] && adv && shd_dly_r[D_SHD-1] |=> out_tdata == '0)
    else $error("shadowed beat gave light");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid line moved during stall");

  a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted beat missing from first stage");

endmodule

>>> tb/plps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plps_checker
// Watches the register, hit and light channels of the point light shader,
// keeps its own copy of the light registers, works out the light added to
// each accepted hit and compares every result beat with the oldest one due.
// ----------------------------------------------------------------------------
module plps_checker
  import plps_pkg::*;
#(
  parameter int SPEC_EXPONENT = SPEC_EXP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    n_err,
  output int                    n_due,
  output int                    n_checked
);

  logic [FIX_W-1:0]      lpos [3];
  logic [RGB_W-1:0]      lrgb;
  logic [STRENGTH_W-1:0] lstr;
  logic [FIX_W-1:0]      lreach;
  logic [DIM_W-1:0]      ldim;
  logic [OUT_DATA_W-1:0] light_due [$];

  function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = 0;
    v = x;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic void to_unit(input longint a, b, c, output longint ua, ub, uc);
    logic [63:0] sq;
    logic [63:0] len;
    sq = mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
    len = sqrt_floor(sq);
    if (len == 0) begin
      ua = 0; ub = 0; uc = 0;
    end else begin
      ua = longint'((mag(a) << 30) / len); if (a < 0) ua = -ua;
      ub = longint'((mag(b) << 30) / len); if (b < 0) ub = -ub;
      uc = longint'((mag(c) << 30) / len); if (c < 0) uc = -uc;
    end
  endfunction

  function automatic longint dot_q30(input longint a0, a1, a2, b0, b1, b2);
    return ((a0 * b0) >>> 30) + ((a1 * b1) >>> 30) + ((a2 * b2) >>> 30);
  endfunction

  function automatic logic [OUT_DATA_W-1:0] shade(input logic [IN_DATA_W-1:0] d,
                                                  input logic shadow);
    longint lv [3];
    longint nv [3];
    longint vv [3];
    longint lu [3];
    longint nu [3];
    longint vu [3];
    longint rv [3];
    longint dd, nl, ang, t;
    logic [63:0] sq, p, spec, dch, tot;
    logic [127:0] num, den, bright;
    logic [15:0] shine;
    logic [7:0] c;
    logic ok;
    logic [OUT_DATA_W-1:0] res;
    dd = 0;
    sq = 0;
    spec = 0;
    res = '0;
    shine = d[SHINE_LSB +: SHINE_W];
    for (int i = 0; i < 3; i++) begin
      t = longint'(signed'(lpos[i])) - longint'(signed'(d[HIT_LSB + i*FIX_W +: FIX_W]));
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      lv[i] = t;
      nv[i] = longint'(signed'(d[NORM_LSB + i*FIX_W +: FIX_W]));
      vv[i] = -longint'(signed'(d[VIEW_LSB + i*FIX_W +: FIX_W]));
    end
    if (shadow) return res;
    for (int i = 0; i < 3; i++) begin
      dd += (nv[i] * lv[i]) >>> 16;
      sq += mag(lv[i]) * mag(lv[i]);
    end
    if (dd < 0) dd = 0;
    num = ((128'(dd) * 128'(lstr)) * 128'(lreach)) << 16;
    den = 128'(sq) * 128'(ldim);
    ok = (den != 0) && (num < (den << 32));
    bright = ok ? num / den : '0;
    if (shine != 0) begin
      to_unit(lv[0], lv[1], lv[2], lu[0], lu[1], lu[2]);
      to_unit(nv[0], nv[1], nv[2], nu[0], nu[1], nu[2]);
      to_unit(vv[0], vv[1], vv[2], vu[0], vu[1], vu[2]);
      nl = dot_q30(nu[0], nu[1], nu[2], lu[0], lu[1], lu[2]);
      if (nl > ONE30) nl = ONE30;
      if (nl < -ONE30) nl = -ONE30;
      for (int i = 0; i < 3; i++) rv[i] = ((2 * nl * nu[i]) >>> 30) - lu[i];
      ang = dot_q30(rv[0], rv[1], rv[2], vu[0], vu[1], vu[2]);
      if (ang < 0) ang = 0;
      if (ang > ONE30) ang = ONE30;
      p = 64'(ONE30);
      for (int i = 0; i < SPEC_EXPONENT; i++) p = (p * 64'(ang)) >> 30;
      spec = (64'(lstr) * p * 64'(shine)) >> 30;
    end
    for (int i = 0; i < 3; i++) begin
      c = lrgb[16 - 8*i +: 8];
      if (!ok) dch = (c != 0) ? 64'hFFFF_FFFF : 64'd0;
      else     dch = 64'(c) * bright[63:0];
      tot = dch + spec;
      res[i*FIX_W +: FIX_W] = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
    end
    return res;
  endfunction

  assign n_due = light_due.size();

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (!rst_n) begin
      lpos[0] <= '0; lpos[1] <= '0; lpos[2] <= '0;
      lrgb    <= RGB_RST;
      lstr    <= STRENGTH_RST;
      lreach  <= REACH_RST;
      ldim    <= DIM_RST;
      n_err     <= 0;
      n_checked <= 0;
      light_due.delete();
    end else begin
      if (in_tvalid && in_tready) light_due.push_back(shade(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        n_checked <= n_checked + 1;
        if (light_due.size() == 0) begin
          n_err <= n_err + 1;
          $display("%0t unexpected light beat %h", $time, out_tdata);
        end else begin
          want = light_due.pop_front();
          for (int i = 0; i < 3; i++)
            if (want[i*FIX_W +: FIX_W] !== out_tdata[i*FIX_W +: FIX_W]) begin
              n_err <= n_err + 1;
              if (n_err < 30)
                $display("%0t channel %0d expected %h got %h", $time, i,
                         want[i*FIX_W +: FIX_W], out_tdata[i*FIX_W +: FIX_W]);
            end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIGHT_POS_X: lpos[0] <= cfg_data;
          REG_LIGHT_POS_Y: lpos[1] <= cfg_data;
          REG_LIGHT_POS_Z: lpos[2] <= cfg_data;
          REG_LIGHT_RGB:   lrgb    <= cfg_data[RGB_W-1:0];
          REG_STRENGTH:    lstr    <= cfg_data[STRENGTH_W-1:0];
          REG_REACH:       lreach  <= cfg_data;
          REG_DIM_RATE:    ldim    <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random surface hits through the point light shader
// under several light settings, with bursty input and a stalling output;
// the checker predicts every light beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
  import plps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    n_err, n_due, n_checked;
  int                    n_hits = 0;
  int                    burst_left = 0;
  bit                    hold_now = 0;

  always #2 clk = ~clk;

  point_light_phong_shading u_top (.*);

  plps_checker u_chk (.*);

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // output stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        hold_now = 0;
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        0:       out_tready = 1'b1;
        1:       out_tready = ($urandom_range(0, 1) == 1);
        default: out_tready = ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_hit(input logic [IN_DATA_W-1:0] d, input logic shadow);
    int gap;
    in_tdata  = d;
    in_tuser  = shadow;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_hits++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (n_due != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_fix();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           3: return 32'hFFFF_FFFF;
           default: return 32'h0001_0000;
         endcase
      default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_hit(
      input logic [31:0] hx, hy, hz, nx, ny, nz, vx, vy, vz, input logic [15:0] sh);
    return {sh, vz, vy, vx, nz, ny, nx, hz, hy, hx};
  endfunction

  function automatic logic [15:0] rnd_shine();
    case ($urandom_range(0, 5))
      0:       return 16'h0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;

  initial begin
    logic [31:0] px, py, pz, reach;
    logic [23:0] rgb;
    logic [15:0] str, dim;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset light at origin; directed hits
    send_hit(pack_hit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_hit(pack_hit(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0100), 1'b0);
    send_hit(pack_hit(0, MONE, 0, 0, ONE, 0, 0, ONE, 0, 16'h0100), 1'b0);
    send_hit(pack_hit(0, MONE, 0, 0, ONE, 0, 0, ONE, 0, 16'hFFFF), 1'b0);
    send_hit(pack_hit(0, MONE, 0, 0, ONE, 0, 0, ONE, 0, 16'h0100), 1'b1);
    send_hit(pack_hit(0, MONE, 0, 0, ONE, 0, 0, ONE, 0, 16'h0000), 1'b0);
    send_hit(pack_hit(0, MONE, 0, 0, MONE, 0, 0, ONE, 0, 16'h0100), 1'b0);
    send_hit(pack_hit(ONE, MONE, 0, 0, ONE, 0, MONE, ONE, 0, 16'h0200), 1'b0);
    send_hit(pack_hit(0, MONE, 0, 0, 0, 0, 0, ONE, 0, 16'h0100), 1'b0);
    send_hit(pack_hit(0, MONE, 0, 0, ONE, 0, 0, 0, 0, 16'h0100), 1'b0);
    send_hit(pack_hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF), 1'b0);
    send_hit(pack_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF), 1'b0);
    send_hit(pack_hit(32'hFFFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h0000_0001, 0, 0,
                      16'h0001), 1'b0);
    send_hit(pack_hit(0, 0, 32'h0000_0001, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF,
                      16'h8000), 1'b0);
    send_hit(pack_hit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b1);
    send_hit(pack_hit(0, 32'hFFF0_0000, 0, ONE, ONE, 0, MONE, ONE, 0, 16'h0100), 1'b0);
    drain();

    // an unused index must leave the light untouched
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);

    for (int ph = 0; ph < 6; ph++) begin
      px = rnd_fix(); py = rnd_fix(); pz = rnd_fix();
      case (ph)
        0: begin rgb = 24'hFFFFFF; str = 16'd256; reach = 32'd65536; dim = 16'd256;
           px = 0; py = ONE << 2; pz = 0; end
        1: begin rgb = 24'($urandom); str = 16'($urandom); reach = $urandom;
           dim = 16'($urandom_range(1, 16'hFFFF)); end
        2: begin rgb = 24'h000000; str = 16'hFFFF; reach = 32'hFFFF_FFFF; dim = 16'd1;
           px = 32'h7FFF_FFFF; py = 32'h8000_0000; pz = 32'hFFFF_FFFF; end
        3: begin rgb = 24'hFFFFFF; str = 16'd0; reach = 32'd0; dim = 16'hFFFF;
           px = 32'h8000_0000; py = 32'h7FFF_FFFF; pz = 0; end
        4: begin rgb = 24'($urandom); str = 16'hFFFF; reach = $urandom; dim = 16'd0; end
        default: begin rgb = 24'h00FF00; str = 16'd1; reach = 32'd1; dim = 16'd1; end
      endcase
      write_reg(REG_LIGHT_POS_X, px);
      write_reg(REG_LIGHT_POS_Y, py);
      write_reg(REG_LIGHT_POS_Z, pz);
      write_reg(REG_LIGHT_RGB, {8'h00, rgb});
      write_reg(REG_STRENGTH, {16'h0, str});
      write_reg(REG_REACH, reach);
      write_reg(REG_DIM_RATE, {16'h0, dim});
      if (ph == 1) hold_now = 1;
      for (int k = 0; k < 222; k++)
        send_hit(pack_hit(rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(),
                          rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(), rnd_shine()),
                 $urandom_range(0, 7) == 0);
      drain();
    end

    $display("tb: %0d hits shaded under 7 light settings incl. extremes", n_hits);
    $display("tb: %0d light beats checked, long output hold and idle pauses done",
             n_checked);
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> point_light_phong_shading.f
rtl/core/plps_pkg.sv
rtl/core/plps_isqrt.sv
rtl/core/plps_div.sv
rtl/core/point_light_phong_shading.sv
tb/plps_checker.sv
tb/tb.sv
